// ===== rtl/core/mcar_pkg.sv =====
// Shared types, constants and helper functions for the comb/allpass reverb.
`timescale 1ns / 1ps
package mcar_pkg;

  localparam int COMB_AW   = 14;
  localparam int AP_AW     = 11;
  localparam int COMB_CAP  = 2048;
  localparam int AP_CAP    = 1024;
  localparam int AP_GAIN   = 22938;
  localparam int WET_SCALE = 19661;
  localparam int MUL_AW    = 26;
  localparam int MUL_CW    = 17;
  localparam int MUL_PW    = 44;

  localparam int COMB_TUNE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int AP_TUNE   [4] = '{225, 341, 441, 556};

  typedef logic signed [23:0]       s24_t;
  typedef logic signed [28:0]       rnd_t;
  typedef logic signed [MUL_PW-1:0] prod_t;

  typedef enum logic [2:0] {
    REG_COMB_FB   = 3'd0,
    REG_DAMP      = 3'd1,
    REG_WET       = 3'd2,
    REG_DRY       = 3'd3,
    REG_TRIM      = 3'd4,
    REG_PD_FRAMES = 3'd5,
    REG_PD_FB     = 3'd6,
    REG_HPF_POLE  = 3'd7
  } reg_idx_t;

  function automatic int tuned_len(int t, int cap, int rate, int spread);
    int n;
    n = (t * rate + 22050) / 44100 + spread;
    if (n < 5) n = 5;
    if (n > cap) n = cap;
    return n;
  endfunction

  // offset of line i when lines sit back to back
  function automatic int line_off(bit is_comb, int i, int rate, int spread);
    int acc;
    acc = 0;
    for (int j = 0; j < i; j++) begin
      if (is_comb) acc += tuned_len(COMB_TUNE[j], COMB_CAP, rate, spread);
      else acc += tuned_len(AP_TUNE[j], AP_CAP, rate, spread);
    end
    return acc;
  endfunction

  function automatic s24_t sat24(prod_t v);
    if (v > prod_t'(8388607)) return s24_t'(8388607);
    if (v < -prod_t'(8388608)) return s24_t'(-8388608);
    return v[23:0];
  endfunction

  // round to nearest, ties up, then drop 15 fraction bits
  function automatic rnd_t rnd15(prod_t p);
    prod_t q;
    q = p + prod_t'(16384);
    return q[43:15];
  endfunction

endpackage

// ===== rtl/core/mcar_mul.sv =====
// Shared signed-by-unsigned coefficient multiplier with registered product.
`timescale 1ns / 1ps
module mcar_mul (
  input  logic                              clk,
  input  logic signed [mcar_pkg::MUL_AW-1:0] mul_a,
  input  logic        [mcar_pkg::MUL_CW-1:0] mul_c,
  output mcar_pkg::prod_t                   mul_p
);
  import mcar_pkg::*;

  logic signed [MUL_CW:0] c_s;
  prod_t                  p_nxt;
  prod_t                  p_r;

  always_comb begin
    c_s   = $signed({1'b0, mul_c});
    p_nxt = mul_a * c_s;
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign mul_p = p_r;

endmodule

// ===== rtl/core/mono_comb_allpass_reverb.sv =====
// Top level: mono reverb sequencer over echo, comb and allpass line memories.
`timescale 1ns / 1ps
// Mono reverb: one 16-bit sample in on the in_ stream, one 16-bit sample out on
// the out_ stream. Coefficients are written over the APB-style cfg_ port, only
// while the block is idle, a rule for the user that the block does not enforce;
// register i sits at byte address 4*i. Each request runs through one sequencer
// that shares a single multiplier and three simple dual-port line memories (read
// data registered): pre-delay echo, high-pass, COMB_COUNT combs, ALLPASS_COUNT
// allpasses, mix. The high-pass steps are skipped when it is bypassed. The next
// sample can be accepted in the cycle after the result is registered, so no new
// sample starts while one is still being processed.
// After reset a clearing pass zeroes the line memories while in_tready stays
// low; configuration writes are taken meanwhile.
// The result waits in an output register; while the receiver stalls, the
// sequencer holds its final step and accepts no new sample.
module mono_comb_allpass_reverb #(
  parameter int ECHO_DEPTH    = 32768,
  parameter int SAMPLE_RATE   = 44100,
  parameter int SPREAD_FRAMES = 23,
  parameter int COMB_COUNT    = 8,
  parameter int ALLPASS_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [15:0] in_tdata,     // [15:0] sample_in
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic signed [15:0] out_tdata,    // [15:0] sample_out
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import mcar_pkg::*;

  localparam int EAW   = $clog2(ECHO_DEPTH);
  localparam int CLR_N = (ECHO_DEPTH > (1 << COMB_AW)) ? ECHO_DEPTH : (1 << COMB_AW);
  localparam int CW    = $clog2(CLR_N);

  typedef enum logic [4:0] {
    ST_IDLE, ST_EMUL, ST_EWR, ST_H1, ST_H2, ST_H3,
    ST_CRD, ST_CM1, ST_CRND, ST_CM2, ST_CM3, ST_CM4,
    ST_ARD, ST_AM1, ST_AM2, ST_AM3, ST_AM4,
    ST_X1, ST_X2, ST_X3, ST_X4
  } st_t;

  // configuration registers
  logic [14:0] comb_fb_r, pd_frames_r, pd_fb_r;
  logic [15:0] damp_r, wet_r, dry_r, pole_r;
  logic [6:0]  trim_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_COMB_FB:   cfg_prdata = 32'(comb_fb_r);
      REG_DAMP:      cfg_prdata = 32'(damp_r);
      REG_WET:       cfg_prdata = 32'(wet_r);
      REG_DRY:       cfg_prdata = 32'(dry_r);
      REG_TRIM:      cfg_prdata = 32'(trim_r);
      REG_PD_FRAMES: cfg_prdata = 32'(pd_frames_r);
      REG_PD_FB:     cfg_prdata = 32'(pd_fb_r);
      REG_HPF_POLE:  cfg_prdata = 32'(pole_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comb_fb_r   <= 15'd30278;
      damp_r      <= 16'd14703;
      wet_r       <= 16'd0;
      dry_r       <= 16'd32768;
      trim_r      <= 7'd0;
      pd_frames_r <= 15'd6615;
      pd_fb_r     <= 15'd13107;
      pole_r      <= 16'd32768;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COMB_FB:   comb_fb_r   <= cfg_pwdata[14:0];
        REG_DAMP:      damp_r      <= cfg_pwdata[15:0];
        REG_WET:       wet_r       <= cfg_pwdata[15:0];
        REG_DRY:       dry_r       <= cfg_pwdata[15:0];
        REG_TRIM:      trim_r      <= cfg_pwdata[6:0];
        REG_PD_FRAMES: pd_frames_r <= cfg_pwdata[14:0];
        REG_PD_FB:     pd_fb_r     <= cfg_pwdata[14:0];
        REG_HPF_POLE:  pole_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // clamped coefficients
  logic [14:0] fb_c, pfb_c;
  logic [15:0] dmp_c, wet_c, dry_c, pole_c;
  logic [6:0]  trim_c;
  logic [16:0] dist_c;
  logic        hpf_on;

  always_comb begin
    fb_c   = (comb_fb_r < 15'd22938) ? 15'd22938 :
             (comb_fb_r > 15'd32113) ? 15'd32113 : comb_fb_r;
    pfb_c  = (pd_fb_r > 15'd32113) ? 15'd32113 : pd_fb_r;
    dmp_c  = (damp_r > 16'd32768) ? 16'd32768 : damp_r;
    wet_c  = (wet_r > 16'd32768) ? 16'd32768 : wet_r;
    dry_c  = (dry_r > 16'd32768) ? 16'd32768 : dry_r;
    pole_c = (pole_r > 16'd32768) ? 16'd32768 : pole_r;
    trim_c = (trim_r > 7'd64) ? 7'd64 : trim_r;
    dist_c = (pd_frames_r < 15'd10) ? 17'd10 :
             (17'(pd_frames_r) > 17'(ECHO_DEPTH - 1)) ? 17'(ECHO_DEPTH - 1) :
             17'(pd_frames_r);
    hpf_on = pole_c != 16'd32768;
  end

  // line lengths and offsets, fixed at elaboration
  logic [11:0]        comb_len_a [8];
  logic [COMB_AW-1:0] comb_off_a [8];
  logic [10:0]        ap_len_a   [4];
  logic [AP_AW-1:0]   ap_off_a   [4];

  for (genvar g = 0; g < 8; g++) begin : g_comb
    localparam int LEN = tuned_len(COMB_TUNE[g], COMB_CAP, SAMPLE_RATE, SPREAD_FRAMES);
    localparam int OFF = line_off(1'b1, g, SAMPLE_RATE, SPREAD_FRAMES);
    assign comb_len_a[g] = 12'(LEN);
    assign comb_off_a[g] = COMB_AW'(OFF);
  end

  for (genvar g = 0; g < 4; g++) begin : g_ap
    localparam int LEN = tuned_len(AP_TUNE[g], AP_CAP, SAMPLE_RATE, SPREAD_FRAMES);
    localparam int OFF = line_off(1'b0, g, SAMPLE_RATE, SPREAD_FRAMES);
    assign ap_len_a[g] = 11'(LEN);
    assign ap_off_a[g] = AP_AW'(OFF);
  end

  // sequencer state
  st_t                st_r;
  logic               clr_r;
  logic [CW-1:0]      clr_cnt_r;
  logic [EAW-1:0]     wpos_r;
  logic [2:0]         ci_r;
  logic [1:0]         ai_r;
  logic [10:0]        comb_pos_r [8];
  logic [9:0]         ap_pos_r   [4];
  s24_t               hist_r     [8];
  s24_t               hpf_in_r, hpf_out_r;
  logic signed [15:0] x_r;
  s24_t               e_r, h_r, s_r, t_r, nb_r;
  logic signed [24:0] r_r, w1_r;
  logic signed [16:0] dmix_r;
  logic signed [29:0] sum_r;
  prod_t              acc_r;
  logic [10:0]        cpos_r;
  logic [9:0]         apos_r;
  logic [COMB_AW-1:0] cidx_r;
  logic [AP_AW-1:0]   aidx_r;
  logic               out_tvalid_r;
  logic signed [15:0] out_tdata_r;

  assign in_tready  = (st_r == ST_IDLE) && !clr_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // line memories
  s24_t echo_mem [ECHO_DEPTH];
  s24_t comb_mem [1 << COMB_AW];
  s24_t ap_mem   [1 << AP_AW];
  s24_t echo_rd_r, comb_rd_r, ap_rd_r;

  logic               echo_we, comb_we, ap_we;
  logic [EAW-1:0]     echo_wa, echo_ra;
  logic [COMB_AW-1:0] comb_wa, comb_ra;
  logic [AP_AW-1:0]   ap_wa, ap_ra;
  s24_t               echo_wd, comb_wd, ap_wd;

  always_ff @(posedge clk) begin
    if (echo_we) echo_mem[echo_wa] <= echo_wd;
    echo_rd_r <= echo_mem[echo_ra];
  end

  always_ff @(posedge clk) begin
    if (comb_we) comb_mem[comb_wa] <= comb_wd;
    comb_rd_r <= comb_mem[comb_ra];
  end

  always_ff @(posedge clk) begin
    if (ap_we) ap_mem[ap_wa] <= ap_wd;
    ap_rd_r <= ap_mem[ap_ra];
  end

  // shared multiplier
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_CW-1:0]        mul_c;
  prod_t                    mul_p;

  mcar_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_c (mul_c),
    .mul_p (mul_p)
  );

  // datapath
  logic [17:0]        rd_calc;
  logic [11:0]        c_lim;
  logic [10:0]        a_lim;
  logic [10:0]        c_pos_use;
  logic [9:0]         a_pos_use;
  logic [11:0]        c_pos_inc;
  logic [10:0]        a_pos_inc;
  rnd_t               p_rnd;
  s24_t               e_val, h_val, nb_val, s_ap, comb_wr_val;
  rnd_t               comb_o;
  logic signed [29:0] sum_nxt;
  prod_t              hpf_q;
  logic signed [29:0] mix_o;
  logic signed [15:0] mix_sat;
  logic               clr_in_echo;

  always_comb begin
    rd_calc = ({1'b0, 17'(wpos_r)} >= {1'b0, dist_c}) ?
              18'(wpos_r) - 18'(dist_c) :
              18'(wpos_r) + 18'(ECHO_DEPTH) - 18'(dist_c);

    c_lim = (comb_len_a[ci_r] > 12'(trim_c)) ? comb_len_a[ci_r] - 12'(trim_c) : 12'd1;
    a_lim = (ap_len_a[ai_r] > 11'(trim_c)) ? ap_len_a[ai_r] - 11'(trim_c) : 11'd1;
    c_pos_use = (12'(comb_pos_r[ci_r]) >= c_lim) ? 11'd0 : comb_pos_r[ci_r];
    a_pos_use = (11'(ap_pos_r[ai_r]) >= a_lim) ? 10'd0 : ap_pos_r[ai_r];
    c_pos_inc = 12'(cpos_r) + 12'd1;
    a_pos_inc = 11'(apos_r) + 11'd1;

    p_rnd       = rnd15(mul_p);
    e_val       = sat24(prod_t'(x_r) + prod_t'(p_rnd));
    hpf_q       = acc_r + mul_p + prod_t'(32768);
    h_val       = sat24(hpf_q >>> 16);
    comb_o      = rnd15(acc_r + mul_p);
    comb_wr_val = sat24(prod_t'(h_r) + prod_t'(comb_o));
    sum_nxt     = sum_r + 30'(comb_o);
    nb_val      = sat24(prod_t'(p_rnd) + prod_t'(s_r));
    s_ap        = sat24(prod_t'(t_r) - prod_t'(p_rnd));
    mix_o       = 30'(p_rnd) + 30'(dmix_r);
    mix_sat     = (mix_o > 30'sd32767) ? 16'sh7fff :
                  (mix_o < -30'sd32768) ? 16'sh8000 : mix_o[15:0];
    clr_in_echo = {1'b0, clr_cnt_r} < (CW + 1)'(ECHO_DEPTH);
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    unique case (st_r)
      ST_EMUL: begin mul_a = MUL_AW'(echo_rd_r); mul_c = 17'(pfb_c); end
      ST_H1: begin
        mul_a = MUL_AW'(e_r) - MUL_AW'(hpf_in_r);
        mul_c = 17'd32768 + 17'(pole_c);
      end
      ST_H2:   begin mul_a = MUL_AW'(hpf_out_r); mul_c = {pole_c, 1'b0}; end
      ST_CM1:  begin mul_a = MUL_AW'(comb_rd_r); mul_c = 17'(fb_c); end
      ST_CM2:  begin mul_a = MUL_AW'(r_r); mul_c = 17'd32768 - 17'(dmp_c); end
      ST_CM3:  begin mul_a = MUL_AW'(hist_r[ci_r]); mul_c = 17'(dmp_c); end
      ST_AM1:  begin mul_a = MUL_AW'(ap_rd_r); mul_c = 17'(AP_GAIN); end
      ST_AM3:  begin mul_a = MUL_AW'(nb_r); mul_c = 17'(AP_GAIN); end
      ST_X1:   begin mul_a = MUL_AW'(s_r); mul_c = 17'(wet_c); end
      ST_X2:   begin mul_a = MUL_AW'(x_r); mul_c = 17'(dry_c); end
      // keep issuing the wet scaling so the product holds while stalled
      ST_X3, ST_X4: begin mul_a = MUL_AW'(w1_r); mul_c = 17'(WET_SCALE); end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    echo_ra = EAW'(rd_calc);
    echo_we = clr_r ? clr_in_echo : (st_r == ST_EWR);
    echo_wa = clr_r ? EAW'(clr_cnt_r) : wpos_r;
    echo_wd = clr_r ? '0 : e_val;

    comb_ra = comb_off_a[ci_r] + COMB_AW'(c_pos_use);
    comb_we = clr_r || (st_r == ST_CM4);
    comb_wa = clr_r ? COMB_AW'(clr_cnt_r) : cidx_r;
    comb_wd = clr_r ? '0 : comb_wr_val;

    ap_ra = ap_off_a[ai_r] + AP_AW'(a_pos_use);
    ap_we = clr_r || (st_r == ST_AM2);
    ap_wa = clr_r ? AP_AW'(clr_cnt_r) : aidx_r;
    ap_wd = clr_r ? '0 : nb_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      clr_r        <= 1'b1;
      clr_cnt_r    <= '0;
      wpos_r       <= '0;
      ci_r         <= '0;
      ai_r         <= '0;
      hpf_in_r     <= '0;
      hpf_out_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        comb_pos_r[i] <= '0;
        hist_r[i]     <= '0;
      end
      for (int i = 0; i < 4; i++) ap_pos_r[i] <= '0;
    end else begin
      if (out_tvalid_r && out_tready && st_r != ST_X4) out_tvalid_r <= 1'b0;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(CLR_N - 1)) clr_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            x_r  <= in_tdata;
            st_r <= ST_EMUL;
          end
        end
        ST_EMUL: st_r <= ST_EWR;
        ST_EWR: begin
          e_r    <= e_val;
          wpos_r <= (wpos_r == EAW'(ECHO_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
          ci_r   <= '0;
          sum_r  <= '0;
          if (hpf_on) begin
            st_r <= ST_H1;
          end else begin
            h_r  <= e_val;
            st_r <= ST_CRD;
          end
        end
        ST_H1: st_r <= ST_H2;
        ST_H2: begin
          acc_r <= mul_p;
          st_r  <= ST_H3;
        end
        ST_H3: begin
          h_r       <= h_val;
          hpf_in_r  <= e_r;
          hpf_out_r <= h_val;
          st_r      <= ST_CRD;
        end
        ST_CRD: begin
          cpos_r <= c_pos_use;
          cidx_r <= comb_ra;
          st_r   <= ST_CM1;
        end
        ST_CM1: st_r <= ST_CRND;
        ST_CRND: begin
          r_r  <= 25'(p_rnd);
          st_r <= ST_CM2;
        end
        ST_CM2: st_r <= ST_CM3;
        ST_CM3: begin
          acc_r <= mul_p;
          st_r  <= ST_CM4;
        end
        ST_CM4: begin
          hist_r[ci_r]     <= sat24(prod_t'(comb_o));
          comb_pos_r[ci_r] <= (c_pos_inc >= c_lim) ? 11'd0 : c_pos_inc[10:0];
          sum_r            <= sum_nxt;
          if (ci_r == 3'(COMB_COUNT - 1)) begin
            s_r  <= sat24(prod_t'(sum_nxt));
            ai_r <= '0;
            st_r <= ST_ARD;
          end else begin
            ci_r <= ci_r + 1'b1;
            st_r <= ST_CRD;
          end
        end
        ST_ARD: begin
          apos_r <= a_pos_use;
          aidx_r <= ap_ra;
          st_r   <= ST_AM1;
        end
        ST_AM1: begin
          t_r  <= ap_rd_r;
          st_r <= ST_AM2;
        end
        ST_AM2: begin
          nb_r <= nb_val;
          st_r <= ST_AM3;
        end
        ST_AM3: st_r <= ST_AM4;
        ST_AM4: begin
          s_r            <= s_ap;
          ap_pos_r[ai_r] <= (a_pos_inc >= a_lim) ? 10'd0 : a_pos_inc[9:0];
          if (ai_r == 2'(ALLPASS_COUNT - 1)) begin
            st_r <= ST_X1;
          end else begin
            ai_r <= ai_r + 1'b1;
            st_r <= ST_ARD;
          end
        end
        ST_X1: st_r <= ST_X2;
        ST_X2: begin
          w1_r <= 25'(p_rnd);
          st_r <= ST_X3;
        end
        ST_X3: begin
          dmix_r <= 17'(p_rnd);
          st_r   <= ST_X4;
        end
        ST_X4: begin
          // hold the final product until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= mix_sat;
            out_tvalid_r <= 1'b1;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_mono_comb_allpass_reverb.sv =====
// Self-checking testbench for the mono comb/allpass reverb top level.
`timescale 1ns / 1ps
module tb_mono_comb_allpass_reverb;
  import mcar_pkg::*;

  localparam int RATE      = 44100;
  localparam int SPREAD    = 23;
  localparam int ECHO_SIZE = 32768;
  localparam int CYCLE_CAP = 2000000;
  localparam int SETTLE    = 200;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic signed [15:0] in_tdata;     // [15:0] sample_in
  logic               out_tvalid;
  logic               out_tready;
  logic signed [15:0] out_tdata;    // [15:0] sample_out
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [4:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  mono_comb_allpass_reverb i_dut (.*);

  // register shadow, held at the written width
  int unsigned         reg_shadow [8];
  int                  echo_mem [ECHO_SIZE];
  int unsigned         echo_wr;
  int                  comb_mem [1 << COMB_AW];
  int unsigned         comb_pos [8];
  int                  damp_hist [8];
  int                  ap_mem [1 << AP_AW];
  int unsigned         ap_pos [4];
  int                  hpf_in;
  int                  hpf_out;

  logic signed [15:0]  sample_queue [$];
  logic signed [15:0]  expected_out [$];
  int                  fail_count;
  int                  cycle_count;
  bit                  in_taken;
  int                  burst_left;
  int                  gap_left;
  int                  hold_left;
  bit                  long_hold_req;
  bit                  calm;

  function automatic longint sat_24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // round to nearest, ties up, Q1.15 coefficient
  function automatic longint qmul(longint a, longint c);
    return (a * c + 16384) >>> 15;
  endfunction

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned line_len(int tune, int cap);
    int unsigned n;
    n = (tune * RATE + 22050) / 44100 + SPREAD;
    if (n < 5) n = 5;
    if (n > cap) n = cap;
    return n;
  endfunction

  function automatic logic signed [15:0] reverb_sample(logic signed [15:0] smp);
    longint      x, e, h, s, o, sum, p, t, nb;
    int unsigned echo_dist, pfb, fb, dmp, pole, trim, rd, off, len, lim, idx;
    x    = smp;
    echo_dist = clamp_u(reg_shadow[REG_PD_FRAMES], 10, ECHO_SIZE - 1);
    pfb  = clamp_u(reg_shadow[REG_PD_FB], 0, 32113);
    fb   = clamp_u(reg_shadow[REG_COMB_FB], 22938, 32113);
    dmp  = clamp_u(reg_shadow[REG_DAMP], 0, 32768);
    pole = clamp_u(reg_shadow[REG_HPF_POLE], 0, 32768);
    trim = clamp_u(reg_shadow[REG_TRIM], 0, 64);

    rd = echo_wr >= echo_dist ? echo_wr - echo_dist : echo_wr + ECHO_SIZE - echo_dist;
    e = sat_24(x + qmul(echo_mem[rd], pfb));
    echo_mem[echo_wr] = int'(e);
    echo_wr = (echo_wr + 1) % ECHO_SIZE;

    h = e;
    if (pole < 32768) begin
      p = (e - hpf_in) * longint'(32768 + pole) + longint'(hpf_out) * longint'(2 * pole);
      h = sat_24((p + 32768) >>> 16);
      hpf_in  = int'(e);
      hpf_out = int'(h);
    end

    sum = 0;
    off = 0;
    for (int i = 0; i < 8; i++) begin
      len = line_len(COMB_TUNE[i], COMB_CAP);
      lim = len > trim ? len - trim : 1;
      if (comb_pos[i] >= lim) comb_pos[i] = 0;
      idx = (off + comb_pos[i]) & ((1 << COMB_AW) - 1);
      o = qmul(comb_mem[idx], fb);
      o = (o * longint'(32768 - dmp) + longint'(damp_hist[i]) * longint'(dmp) + 16384) >>> 15;
      damp_hist[i] = int'(sat_24(o));
      comb_mem[idx] = int'(sat_24(h + o));
      sum += o;
      comb_pos[i]++;
      if (comb_pos[i] >= lim) comb_pos[i] = 0;
      off += len;
    end
    s = sat_24(sum);

    off = 0;
    for (int k = 0; k < 4; k++) begin
      len = line_len(AP_TUNE[k], AP_CAP);
      lim = len > trim ? len - trim : 1;
      if (ap_pos[k] >= lim) ap_pos[k] = 0;
      idx = (off + ap_pos[k]) & ((1 << AP_AW) - 1);
      t = ap_mem[idx];
      nb = sat_24(qmul(t, AP_GAIN) + s);
      ap_mem[idx] = int'(nb);
      s = sat_24(t - qmul(nb, AP_GAIN));
      ap_pos[k]++;
      if (ap_pos[k] >= lim) ap_pos[k] = 0;
      off += len;
    end

    o = qmul(qmul(s, clamp_u(reg_shadow[REG_WET], 0, 32768)), WET_SCALE)
      + qmul(x, clamp_u(reg_shadow[REG_DRY], 0, 32768));
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // accept requests, predict, and check results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end else begin
      in_taken = rst_n && in_tvalid && in_tready;
      if (in_taken) expected_out.push_back(reverb_sample(in_tdata));
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected sample_out, expected none, actual %0d", $realtime,
                   out_tdata);
          fail_count++;
        end else begin
          if (out_tdata !== expected_out[0]) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $realtime,
                     expected_out[0], out_tdata);
            fail_count++;
          end
          void'(expected_out.pop_front());
        end
      end
    end
  end

  // sender: bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_tdata  <= sample_queue.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = calm ? 0 : $urandom_range(0, 150);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 40) == 0) hold_left = $urandom_range(1, 120);
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    int unsigned mask;
    case (idx) inside
      REG_COMB_FB, REG_PD_FRAMES, REG_PD_FB: mask = 32'h7fff;
      REG_TRIM: mask = 32'h7f;
      default: mask = 32'hffff;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    reg_shadow[idx] = val & mask;
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_tvalid || expected_out.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) sample_queue.push_back(16'($urandom));
      else if (mode < 8) sample_queue.push_back(16'($signed($urandom_range(0, 2047)) - 1024));
      else sample_queue.push_back(mode == 8 ? 16'sh7fff : 16'sh8000);
    end
  endtask

  initial begin
    reg_shadow  = '{30278, 14703, 0, 32768, 0, 6615, 13107, 32768};
    echo_wr     = 0;
    hpf_in      = 0;
    hpf_out     = 0;
    fail_count  = 0;
    cycle_count = 0;
    in_taken    = 1'b0;
    burst_left  = 0;
    gap_left    = 0;
    hold_left   = 0;
    long_hold_req = 1'b0;
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, dry only: sample extremes
    calm = 1'b1;
    sample_queue = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555, -16'sh5556};
    wait_idle();

    // full wet, shortest echo, bypassed high-pass, largest trim, strongest feedback
    write_reg(REG_COMB_FB, 32113);
    write_reg(REG_DAMP, 0);
    write_reg(REG_WET, 32768);
    write_reg(REG_DRY, 0);
    write_reg(REG_TRIM, 64);
    write_reg(REG_PD_FRAMES, 10);
    write_reg(REG_PD_FB, 32113);
    write_reg(REG_HPF_POLE, 32768);
    calm = 1'b0;
    sample_queue = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000};
    long_hold_req = 1'b1;
    queue_random(300);
    wait_idle();

    // weakest feedback, full damping, high-pass at pole zero, longest echo
    write_reg(REG_COMB_FB, 22938);
    write_reg(REG_DAMP, 32768);
    write_reg(REG_WET, 20000);
    write_reg(REG_DRY, 32768);
    write_reg(REG_TRIM, 0);
    write_reg(REG_PD_FRAMES, 32767);
    write_reg(REG_PD_FB, 0);
    write_reg(REG_HPF_POLE, 0);
    sample_queue = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    queue_random(250);
    wait_idle();

    // out-of-range writes clamp: wet and dry over unity, trim and echo past limits
    write_reg(REG_COMB_FB, 0);
    write_reg(REG_DAMP, 65535);
    write_reg(REG_WET, 65535);
    write_reg(REG_DRY, 65535);
    write_reg(REG_TRIM, 127);
    write_reg(REG_PD_FRAMES, 3);
    write_reg(REG_PD_FB, 32767);
    write_reg(REG_HPF_POLE, 32767);
    sample_queue = '{16'sh7fff, 16'sh8000, 16'sh7fff};
    queue_random(150);
    wait_idle();

    // random settings over full register widths; echo distance 10 to 400
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 8; r++) write_reg(reg_idx_t'(r), $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_HPF_POLE, 32768);
      write_reg(REG_PD_FRAMES, $urandom_range(10, 400));
      calm = ph == 2;
      queue_random(130);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mono_comb_allpass_reverb.f =====
rtl/core/mcar_pkg.sv
rtl/core/mcar_mul.sv
rtl/core/mono_comb_allpass_reverb.sv
dv/tb_mono_comb_allpass_reverb.sv
